[src/chs_pkg.sv]
// Shared constants for the cosine hemisphere sampler.
// Used by cosine_hemisphere_sampler, chs_horner_step and the testbench; depends on nothing.
`default_nettype none

package chs_pkg;

    // Q30 fixed point used through the angle and trig datapath
    localparam int unsigned FRAC_BITS = 30;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // pi/4 in Q30
    localparam logic [29:0] QUARTER_PI_Q30 = 30'd843314857;

    // Quotient of minor/major offset: one integer bit plus 30 fraction bits
    localparam int unsigned QUOT_BITS = 31;

    // Register stages per Horner step (product, reciprocal, correction)
    localparam int unsigned STEP_STAGES = 3;

    // Horner divisors, innermost term first
    localparam int unsigned SIN_STEPS = 5;
    localparam int unsigned COS_STEPS = 6;
    localparam int unsigned SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};
    localparam int unsigned COS_DIV [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

endpackage

`default_nettype wire

[src/cosine_hemisphere_sampler.sv]
// Cosine-weighted hemisphere sampler, concentric disk mapping, top level.
// Depends on chs_pkg and chs_horner_step.
//
// Usage:
//   Input channel: i_valid / o_stall with i_rand_u, i_rand_v (unsigned
//   0.SAMPLE_BITS). Output channel: o_valid / i_stall with o_disk_x,
//   o_height, o_disk_z (signed 1.(COORD_BITS-1), height unsigned).
//   A transaction completes on a rising edge with valid high, stall low.
//   Throughput: one transaction per cycle, in and out, while the receiver does not stall.
//   Pipeline stages: 1 offset stage, 31 quotient stages (one bit each),
//   2 angle multiply stages, 1 square stage, 18 sine/cosine Horner
//   stages, 2 scaling stages, 2 radius stages and COORD_BITS
//   square-root stages (one bit each).
//   The whole pipeline advances together; when the receiver stalls with a
//   result waiting, every stage holds and o_stall goes high in that cycle.
//   Reset (synchronous, active low) clears all valid bits; no result is
//   presented until new input arrives.
`default_nettype none

module cosine_hemisphere_sampler #(
    parameter int SAMPLE_BITS = 16,
    parameter int COORD_BITS  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [SAMPLE_BITS-1:0]       i_rand_u,
    input  wire logic [SAMPLE_BITS-1:0]       i_rand_v,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic signed [COORD_BITS-1:0]      o_disk_x,
    output logic        [COORD_BITS-2:0]      o_height,
    output logic signed [COORD_BITS-1:0]      o_disk_z
);

    localparam int SB        = SAMPLE_BITS;
    localparam int CB        = COORD_BITS;
    localparam int DIV_ST    = int'(chs_pkg::QUOT_BITS);
    localparam int HORN_ST   = int'(chs_pkg::COS_STEPS * chs_pkg::STEP_STAGES);
    localparam int SIN_ST    = int'(chs_pkg::SIN_STEPS * chs_pkg::STEP_STAGES);
    localparam int LAT       = 1 + DIV_ST + 2 + 1 + HORN_ST + 2 + 2 + CB;
    localparam int SHIFT     = SB + 30 - (CB - 1);
    localparam int PW        = SB + 32;
    localparam int DW        = 2 * CB;

    typedef struct packed {
        logic          zero;
        logic          xmaj;
        logic          negx;
        logic          negz;
        logic [SB:0]   major;
    } t_side;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] z;
    } t_coord;

    logic            w_adv;
    logic [LAT-1:0]  r_vld;

    // Global advance: the output register frees up or is empty
    assign w_adv   = !r_vld[LAT-1] || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ---------------- offsets and major axis ----------------
    logic [SB:0] w_ax;
    logic [SB:0] w_ay;
    t_side       w_side_in;
    t_side       r_side_a;
    logic [SB:0] r_minor_a;

    assign w_ax = i_rand_u[SB-1] ? {1'b0, i_rand_u[SB-2:0], 1'b0}
                                 : ({1'b1, {SB{1'b0}}} - {i_rand_u, 1'b0});
    assign w_ay = i_rand_v[SB-1] ? {1'b0, i_rand_v[SB-2:0], 1'b0}
                                 : ({1'b1, {SB{1'b0}}} - {i_rand_v, 1'b0});

    always_comb begin
        w_side_in.zero  = (w_ax == '0) && (w_ay == '0);
        w_side_in.xmaj  = w_ax > w_ay;
        w_side_in.negx  = !i_rand_u[SB-1];
        w_side_in.negz  = !i_rand_v[SB-1];
        w_side_in.major = (w_ax > w_ay) ? w_ax : w_ay;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side_a  <= w_side_in;
            r_minor_a <= (w_ax > w_ay) ? w_ay : w_ax;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    logic [SB+1:0] r_rem   [DIV_ST];
    logic [30:0]   r_q     [DIV_ST];
    t_side         r_dside [DIV_ST];

    for (genvar k = 0; k < DIV_ST; k++) begin : g_div
        logic [SB+1:0] w_rin;
        logic [30:0]   w_qin;
        t_side         w_sin;
        logic [SB+1:0] w_trial;
        logic [SB+1:0] w_maj;
        logic          w_bit;

        if (k == 0) begin : g_first
            assign w_rin   = {1'b0, r_minor_a};
            assign w_qin   = '0;
            assign w_sin   = r_side_a;
            assign w_trial = w_rin;
        end else begin : g_next
            assign w_rin   = r_rem[k-1];
            assign w_qin   = r_q[k-1];
            assign w_sin   = r_dside[k-1];
            assign w_trial = {w_rin[SB:0], 1'b0};
        end

        assign w_maj = {1'b0, w_sin.major};
        assign w_bit = w_trial >= w_maj;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rem[k]   <= w_bit ? (w_trial - w_maj) : w_trial;
                r_q[k]     <= {w_qin[29:0], w_bit};
                r_dside[k] <= w_sin;
            end
        end
    end

    // ---------------- angle a = q * pi/4, split multiply ----------------
    logic [44:0] r_ph;
    logic [45:0] r_pl;
    t_side       r_mside0;
    logic [61:0] w_asum;
    logic [29:0] r_ang;
    t_side       r_mside1;

    assign w_asum = 62'({r_ph, 16'b0}) + 62'(r_pl);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ph     <= 45'(r_q[DIV_ST-1][30:16]) * 45'(chs_pkg::QUARTER_PI_Q30);
            r_pl     <= 46'(r_q[DIV_ST-1][15:0]) * 46'(chs_pkg::QUARTER_PI_Q30);
            r_mside0 <= r_dside[DIV_ST-1];
            r_ang    <= w_asum[59:30];
            r_mside1 <= r_mside0;
        end
    end

    // ---------------- a squared ----------------
    logic [59:0] w_sq;
    logic [29:0] r_a2;
    logic [29:0] r_qa;
    t_side       r_qside;

    assign w_sq = 60'(r_ang) * 60'(r_ang);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a2    <= w_sq[59:30];
            r_qa    <= r_ang;
            r_qside <= r_mside1;
        end
    end

    // ---------------- sine and cosine Horner chains ----------------
    logic [29:0] w_sa2 [chs_pkg::SIN_STEPS+1];
    logic [30:0] w_st  [chs_pkg::SIN_STEPS+1];
    logic [29:0] w_ca2 [chs_pkg::COS_STEPS+1];
    logic [30:0] w_ct  [chs_pkg::COS_STEPS+1];

    assign w_sa2[0] = r_a2;
    assign w_st[0]  = chs_pkg::Q30_ONE;
    assign w_ca2[0] = r_a2;
    assign w_ct[0]  = chs_pkg::Q30_ONE;

    for (genvar i = 0; i < chs_pkg::SIN_STEPS; i++) begin : g_sin
        chs_horner_step #(
            .DIV (chs_pkg::SIN_DIV[i])
        ) u_step (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a2  (w_sa2[i]),
            .i_t   (w_st[i]),
            .o_a2  (w_sa2[i+1]),
            .o_t   (w_st[i+1])
        );
    end

    for (genvar i = 0; i < chs_pkg::COS_STEPS; i++) begin : g_cos
        chs_horner_step #(
            .DIV (chs_pkg::COS_DIV[i])
        ) u_step (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a2  (w_ca2[i]),
            .i_t   (w_ct[i]),
            .o_a2  (w_ca2[i+1]),
            .o_t   (w_ct[i+1])
        );
    end

    // angle and side data ride alongside the chains
    logic [29:0] r_adly  [SIN_ST];
    t_side       r_hside [HORN_ST];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_adly[0]  <= r_qa;
            r_hside[0] <= r_qside;
            for (int j = 1; j < SIN_ST; j++) begin
                r_adly[j] <= r_adly[j-1];
            end
            for (int j = 1; j < HORN_ST; j++) begin
                r_hside[j] <= r_hside[j-1];
            end
        end
    end

    // sine = a * t, then two delay stages to meet the cosine chain
    logic [60:0] w_sp;
    logic [30:0] r_s0;
    logic [30:0] r_s1;
    logic [30:0] r_s2;

    assign w_sp = 61'(w_st[chs_pkg::SIN_STEPS]) * 61'(r_adly[SIN_ST-1]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0 <= w_sp[60:30];
            r_s1 <= r_s0;
            r_s2 <= r_s1;
        end
    end

    // ---------------- scale to output coordinates ----------------
    t_side         w_hs;
    logic [30:0]   w_fx;
    logic [30:0]   w_fz;
    logic [PW-1:0] r_px;
    logic [PW-1:0] r_pz;
    t_side         r_xside;

    assign w_hs = r_hside[HORN_ST-1];
    assign w_fx = w_hs.xmaj ? w_ct[chs_pkg::COS_STEPS] : r_s2;
    assign w_fz = w_hs.xmaj ? r_s2 : w_ct[chs_pkg::COS_STEPS];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_px    <= PW'(w_hs.major) * PW'(w_fx);
            r_pz    <= PW'(w_hs.major) * PW'(w_fz);
            r_xside <= w_hs;
        end
    end

    // round half up, then saturate the magnitude for the sign
    function automatic logic [CB-1:0] f_sat(input logic [PW-1:0] p, input logic neg);
        logic [PW:0]   v;
        logic [PW:0]   lim;
        v   = ((PW+1)'(p) + ((PW+1)'(1) << (SHIFT - 1))) >> SHIFT;
        lim = neg ? ((PW+1)'(1) << (CB - 1)) : (((PW+1)'(1) << (CB - 1)) - (PW+1)'(1));
        if (v > lim) begin
            v = lim;
        end
        return v[CB-1:0];
    endfunction

    logic [CB-1:0] w_xmag;
    logic [CB-1:0] w_zmag;
    logic [CB-1:0] r_xmag;
    logic [CB-1:0] r_zmag;
    t_coord        r_xc;

    assign w_xmag = r_xside.zero ? '0 : f_sat(r_px, r_xside.negx);
    assign w_zmag = r_xside.zero ? '0 : f_sat(r_pz, r_xside.negz);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xmag <= w_xmag;
            r_zmag <= w_zmag;
            r_xc.x <= r_xside.negx ? (CB'(0) - w_xmag) : w_xmag;
            r_xc.z <= r_xside.negz ? (CB'(0) - w_zmag) : w_zmag;
        end
    end

    // ---------------- radicand 1 - x^2 - z^2 ----------------
    logic [DW-1:0] r_sqx;
    logic [DW-1:0] r_sqz;
    t_coord        r_rc0;
    logic [DW:0]   w_sum;
    logic [DW:0]   w_one;
    logic [DW-1:0] r_rad;
    t_coord        r_rc1;

    assign w_sum = (DW+1)'(r_sqx) + (DW+1)'(r_sqz);
    assign w_one = (DW+1)'(1) << (DW - 2);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sqx <= DW'(r_xmag) * DW'(r_xmag);
            r_sqz <= DW'(r_zmag) * DW'(r_zmag);
            r_rc0 <= r_xc;
            r_rad <= (w_one > w_sum) ? DW'(w_one - w_sum) : '0;
            r_rc1 <= r_rc0;
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic [DW-1:0] r_rn  [CB];
    logic [DW-1:0] r_res [CB];
    t_coord        r_sc  [CB];

    for (genvar k = 0; k < CB; k++) begin : g_sqrt
        localparam logic [DW-1:0] BIT = DW'(1) << (2 * (CB - 1 - k));
        logic [DW-1:0] w_nin;
        logic [DW-1:0] w_rin;
        t_coord        w_cin;
        logic [DW-1:0] w_try;

        if (k == 0) begin : g_first
            assign w_nin = r_rad;
            assign w_rin = '0;
            assign w_cin = r_rc1;
        end else begin : g_next
            assign w_nin = r_rn[k-1];
            assign w_rin = r_res[k-1];
            assign w_cin = r_sc[k-1];
        end

        assign w_try = w_rin + BIT;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (w_nin >= w_try) begin
                    r_rn[k]  <= w_nin - w_try;
                    r_res[k] <= (w_rin >> 1) + BIT;
                end else begin
                    r_rn[k]  <= w_nin;
                    r_res[k] <= w_rin >> 1;
                end
                r_sc[k] <= w_cin;
            end
        end
    end

    // ---------------- outputs ----------------
    assign o_disk_x = r_sc[CB-1].x;
    assign o_disk_z = r_sc[CB-1].z;
    assign o_height = (r_res[CB-1] >= (DW'(1) << (CB - 1))) ? '1 : r_res[CB-1][CB-2:0];

endmodule

`default_nettype wire

[src/chs_horner_step.sv]
// One Horner step t' = 1 - floor(floor(a2 * t / 2^30) / DIV) in Q30, three stages.
// Depends on chs_pkg.
`default_nettype none

module chs_horner_step #(
    parameter int unsigned DIV = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [29:0] i_a2,
    input  wire logic [30:0] i_t,
    output logic      [29:0] o_a2,
    output logic      [30:0] o_t
);

    // floor(2^32 / DIV); estimate is at most one below the true quotient
    localparam logic [32:0] RECIP = 33'((64'(1) << 32) / DIV);

    logic [60:0] w_prod;
    logic [63:0] w_rprod;
    logic [30:0] w_q0;
    logic [30:0] w_rem;
    logic [30:0] w_quot;

    logic [30:0] r_m0;
    logic [29:0] r_a2_0;
    logic [63:0] r_p1;
    logic [30:0] r_m1;
    logic [29:0] r_a2_1;
    logic [30:0] r_t2;
    logic [29:0] r_a2_2;

    // stage 0: Q30 product
    assign w_prod = 61'(i_a2) * 61'(i_t);

    // stage 1: reciprocal multiply
    assign w_rprod = 64'(r_m0) * 64'(RECIP);

    // stage 2: quotient correction and subtract from one
    assign w_q0   = r_p1[62:32];
    assign w_rem  = r_m1 - 31'(w_q0 * 31'(DIV));
    assign w_quot = (w_rem >= 31'(DIV)) ? w_q0 + 31'd1 : w_q0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0   <= w_prod[60:30];
            r_a2_0 <= i_a2;
            r_p1   <= w_rprod;
            r_m1   <= r_m0;
            r_a2_1 <= r_a2_0;
            r_t2   <= chs_pkg::Q30_ONE - w_quot;
            r_a2_2 <= r_a2_1;
        end
    end

    assign o_a2 = r_a2_2;
    assign o_t  = r_t2;

endmodule

`default_nettype wire

[src/chs_checker.sv]
// Port-level assertions for cosine_hemisphere_sampler, bound to the top level.
// Depends on cosine_hemisphere_sampler.
`default_nettype none

module chs_checker #(
    parameter int SAMPLE_BITS = 16,
    parameter int COORD_BITS  = 16
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_valid,
    input wire logic                        o_stall,
    input wire logic [SAMPLE_BITS-1:0]      i_rand_u,
    input wire logic [SAMPLE_BITS-1:0]      i_rand_v,
    input wire logic                        o_valid,
    input wire logic                        i_stall,
    input wire logic [COORD_BITS-1:0]       o_disk_x,
    input wire logic [COORD_BITS-2:0]       o_height,
    input wire logic [COORD_BITS-1:0]       o_disk_z
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // input side only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // disk centre lifts to full height
    a_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_disk_x == '0) && (o_disk_z == '0)) |-> (o_height == '1))
        else $error("centre point height not saturated");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_disk_x) && $stable(o_disk_z)
                                  && $stable(o_height)))
        else $error("stalled transaction changed");

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_rand_u) && $stable(i_rand_v)))
        else $error("stalled input transaction changed");

endmodule

bind cosine_hemisphere_sampler chs_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COORD_BITS  (COORD_BITS)
) u_chs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .i_rand_u (i_rand_u),
    .i_rand_v (i_rand_v),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_disk_x (o_disk_x),
    .o_height (o_height),
    .o_disk_z (o_disk_z)
);

`default_nettype wire

[tb/sv/cosine_hemisphere_sampler_tb.sv]
// Testbench for cosine_hemisphere_sampler: random and directed sample pairs,
// predicted in-bench with Q30 concentric disk math and checked in order.
// Depends on chs_pkg and the cosine_hemisphere_sampler RTL.
`default_nettype none

module cosine_hemisphere_sampler_tb;

    localparam int SB = 16;
    localparam int CB = 16;
    localparam int LATENCY = 57 + CB;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [CB-1:0] disk_x;
        logic        [CB-2:0] height;
        logic signed [CB-1:0] disk_z;
    } t_dir;

    // Q30 product, truncated
    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b) >> 30;
    endfunction

    function automatic longint unsigned q30_sine(longint unsigned a);
        longint unsigned a2, t;
        a2 = q30_mul(a, a);
        t = 64'd1073741824 - a2 / 110;
        t = 64'd1073741824 - q30_mul(a2, t) / 72;
        t = 64'd1073741824 - q30_mul(a2, t) / 42;
        t = 64'd1073741824 - q30_mul(a2, t) / 20;
        t = 64'd1073741824 - q30_mul(a2, t) / 6;
        return q30_mul(a, t);
    endfunction

    function automatic longint unsigned q30_cosine(longint unsigned a);
        longint unsigned a2, t;
        a2 = q30_mul(a, a);
        t = 64'd1073741824 - a2 / 132;
        t = 64'd1073741824 - q30_mul(a2, t) / 90;
        t = 64'd1073741824 - q30_mul(a2, t) / 56;
        t = 64'd1073741824 - q30_mul(a2, t) / 30;
        t = 64'd1073741824 - q30_mul(a2, t) / 12;
        t = 64'd1073741824 - q30_mul(a2, t) / 2;
        return t;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Magnitude times Q30 factor, rounded to coordinate scale and saturated
    function automatic longint scale_coord(longint unsigned mag, longint unsigned f,
                                           bit neg);
        localparam int SH = SB + 30 - (CB - 1);
        longint unsigned v, full;
        full = 64'd1 << (CB - 1);
        v = (mag * f + (64'd1 << (SH - 1))) >> SH;
        if (neg) begin
            if (v > full) v = full;
            return -longint'(v);
        end
        if (v > full - 1) v = full - 1;
        return longint'(v);
    endfunction

    function automatic t_dir predict_direction(logic [SB-1:0] u, logic [SB-1:0] v);
        longint ox, oy, x, z;
        longint unsigned ax, ay, maj, mnr, q, ang, s, c, ux, uz, one, sum, h, full;
        bit xmajor;
        t_dir r;
        full = 64'd1 << (CB - 1);
        ox = longint'({u, 1'b0}) - (64'sd1 << SB);
        oy = longint'({v, 1'b0}) - (64'sd1 << SB);
        ax = ox < 0 ? -ox : ox;
        ay = oy < 0 ? -oy : oy;
        x = 0;
        z = 0;
        if (ax != 0 || ay != 0) begin
            xmajor = ax > ay;
            maj = xmajor ? ax : ay;
            mnr = xmajor ? ay : ax;
            q = (mnr << 30) / maj;
            ang = (q * longint'(chs_pkg::QUARTER_PI_Q30)) >> 30;
            s = q30_sine(ang);
            c = q30_cosine(ang);
            x = scale_coord(maj, xmajor ? c : s, ox < 0);
            z = scale_coord(maj, xmajor ? s : c, oy < 0);
        end
        ux = x < 0 ? -x : x;
        uz = z < 0 ? -z : z;
        one = full * full;
        sum = ux * ux + uz * uz;
        h = int_sqrt(one > sum ? one - sum : 0);
        if (h > full - 1) h = full - 1;
        r.disk_x = x[CB-1:0];
        r.height = h[CB-2:0];
        r.disk_z = z[CB-1:0];
        return r;
    endfunction

    // In-order scoreboard of predicted directions
    class t_direction_board;
        t_dir pending[$];
        int errors;
        int checked;

        function void note_sample(logic [SB-1:0] u, logic [SB-1:0] v);
            pending.push_back(predict_direction(u, v));
        endfunction

        function void check_direction(t_dir got);
            t_dir want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected transaction x=%0d h=%0d z=%0d", $time,
                         got.disk_x, got.height, got.disk_z);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.disk_x !== want.disk_x) begin
                $display("%0t: disk_x expected %0d got %0d", $time, want.disk_x, got.disk_x);
                errors++;
            end
            if (got.height !== want.height) begin
                $display("%0t: height expected %0d got %0d", $time, want.height, got.height);
                errors++;
            end
            if (got.disk_z !== want.disk_z) begin
                $display("%0t: disk_z expected %0d got %0d", $time, want.disk_z, got.disk_z);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic [SB-1:0] i_rand_u = '0;
    logic [SB-1:0] i_rand_v = '0;
    logic o_stall, o_valid;
    logic signed [CB-1:0] o_disk_x, o_disk_z;
    logic [CB-2:0] o_height;

    t_direction_board board = new();
    bit long_hold = 1'b0;
    bit stim_done = 1'b0;
    int idle_cycles = 0;
    int sent = 0;

    cosine_hemisphere_sampler #(.SAMPLE_BITS(SB), .COORD_BITS(CB)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_rand_u(i_rand_u), .i_rand_v(i_rand_v), .o_valid(o_valid),
        .i_stall(i_stall), .o_disk_x(o_disk_x), .o_height(o_height),
        .o_disk_z(o_disk_z)
    );

    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one transaction and hold it until accepted
    task automatic send_sample(logic [SB-1:0] u, logic [SB-1:0] v);
        i_rand_u <= u;
        i_rand_v <= v;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        board.note_sample(u, v);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Wait until every predicted transaction has been checked
    task automatic drain_results();
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    // Result side: sample at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_direction('{o_disk_x, o_height, o_disk_z});
    end

    // Receiver stall pattern, with one long hold-off on request
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (200) @(negedge i_clk);
                i_stall <= 1'b0;
                long_hold = 1'b0;
            end else begin
                n = stim_done ? 0 : gap_len();
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n - 1) @(negedge i_clk);
                    @(negedge i_clk);
                end
                i_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0) repeat ($urandom_range(5, 30)) @(negedge i_clk);
            end
        end
    end

    // Watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("cosine_hemisphere_sampler_tb: errors");
            $finish;
        end
    end

    initial begin
        logic [SB-1:0] u, v;
        logic [SB-1:0] edge_vals [6];
        int k;
        edge_vals = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8001, 16'h0001};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: centre, full-scale corners, ties, axes
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h0000, 16'h8000);
        send_sample(16'hFFFF, 16'h8000);
        send_sample(16'h8000, 16'h0000);
        send_sample(16'h8000, 16'hFFFF);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'h0000, 16'hFFFF);
        send_sample(16'hC000, 16'h4000);
        send_sample(16'h5555, 16'hAAAA);
        for (k = 0; k < 12; k++)
            send_sample(edge_vals[$urandom_range(0, 5)], edge_vals[$urandom_range(0, 5)]);

        // Long receiver hold while the sender keeps offering
        long_hold = 1'b1;
        for (k = 0; k < 120; k++) send_sample($urandom, $urandom);

        // Sender pause until the pipeline drains
        i_valid <= 1'b0;
        drain_results();
        @(negedge i_clk);

        for (k = 0; k < 330; k++) begin
            u = $urandom;
            v = $urandom;
            if ($urandom_range(0, 9) == 0) u = v ^ 16'h0001;
            if ($urandom_range(0, 19) == 0) v = u;
            send_sample(u, v);
            if ($urandom_range(0, 2) == 0) idle_gap(gap_len());
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;

        drain_results();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d sample pairs (corners, centre, ties, random); checked %0d",
                 sent, board.checked);
        $display("directions under random stalls and a long back-pressure hold.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("cosine_hemisphere_sampler_tb: clean");
        else
            $display("cosine_hemisphere_sampler_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
